// ===== rtl/core/two_link_leg_inverse_kinematics_assert.svh =====
// assertion macros for the leg inverse kinematics block
`ifndef TWO_LINK_LEG_INVERSE_KINEMATICS_ASSERT_SVH
`define TWO_LINK_LEG_INVERSE_KINEMATICS_ASSERT_SVH

// check with reset masking
`define TLIK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds around reset
`define TLIK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tlik_pkg.sv =====
`timescale 1ns / 1ps
package tlik_pkg;

   // default parameter values
   localparam int CORDIC_STAGES_DEF = 20;
   localparam int ANGLE_FRAC_DEF    = 16;

   // fixed number formats
   localparam int ATAN_LEN    = 28;
   localparam int SQRT_SCALE  = 20;
   localparam int PHI_SCALE   = 32;
   localparam int HALF_SCALE  = 20;
   localparam int SQ_IN_W     = 52;
   localparam int CORDIC_W    = 52;
   localparam int DIV_W       = 21;
   localparam int COORD_W     = 16;
   localparam int LINK_W      = 14;
   localparam int SERVO_W     = 12;
   localparam int SPAN_W      = 9;
   localparam int LIM_W       = 30;
   localparam int R2_W        = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 14;
   localparam int SERVO_MIN   = 100;
   localparam int SERVO_MAX   = 4000;

   // register reset values
   localparam logic [LINK_W-1:0]  LINK_RST   = 14'd1600;
   localparam logic [SERVO_W-1:0] CENTER_RST = 12'd2048;
   localparam logic [SERVO_W-1:0] RANGE_RST  = 12'd2048;
   localparam logic [SPAN_W-1:0]  SPAN_RST   = 9'd180;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_REACH = 2'd1,
      ST_NOSOL = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINK   = 4'd0,
      CSR_CENTER = 4'd1,
      CSR_RANGE  = 4'd2,
      CSR_SPAN   = 4'd3
   } csr_idx_type;

   typedef struct packed {
      logic [LINK_W-1:0]  link_length;
      logic [SERVO_W-1:0] zero_count;
      logic [SERVO_W-1:0] count_span;
      logic [SPAN_W-1:0]  angle_span;
   } cfg_type;

   // one classified target on its way to the back end
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [R2_W-1:0]           r2;
      logic [R2_W-1:0]           room;
      logic                      reach_err;
   } qent_type;

   // atan(2^-i) in degrees, Q24
   localparam longint ATAN_Q24 [ATAN_LEN] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
      58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
      14, 7
   };

   // table angle rounded half up into the angle format
   function automatic longint atan_angle(input int i, input int frac);
      longint e;
      int     s;
      e = ATAN_Q24[i];
      s = 24 - frac;
      if (s > 0) begin
         return (e + (longint'(1) << (s - 1))) >>> s;
      end
      return e << (-s);
   endfunction

endpackage

// ===== rtl/core/tlik_front.sv =====
`timescale 1ns / 1ps
module tlik_front import tlik_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_target_x,
   input  logic signed [COORD_W-1:0] req_target_y,
   input  logic [LINK_W-1:0]         link_length,
   output logic                      q_push,
   input  logic                      q_full,
   output qent_type                  q_data
);

   logic                      s1_valid_ff;
   logic signed [COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic [R2_W-2:0]           s1_xsq_ff, s1_ysq_ff, s1_xsq_in, s1_ysq_in;
   logic [LIM_W-1:0]          s1_lim_ff, s1_lim_in;
   logic signed [R2_W-1:0]    xsq_full, ysq_full;
   logic [2*LINK_W-1:0]       lsq;
   logic                      s2_valid_ff;
   qent_type                  s2_ent_ff, s2_ent_in;
   logic                      s1_free, s2_free;
   logic [R2_W-1:0]           r2, lim_ext;

   // squares of the coordinates and reach limit
   always_comb begin
      xsq_full  = req_target_x * req_target_x;
      ysq_full  = req_target_y * req_target_y;
      s1_xsq_in = xsq_full[R2_W-2:0];
      s1_ysq_in = ysq_full[R2_W-2:0];
      lsq       = link_length * link_length;
      s1_lim_in = {lsq, 2'b00};
   end

   // distance and reach check
   always_comb begin
      r2        = {1'b0, s1_xsq_ff} + {1'b0, s1_ysq_ff};
      lim_ext   = R2_W'(s1_lim_ff);
      s2_ent_in.x         = s1_x_ff;
      s2_ent_in.y         = s1_y_ff;
      s2_ent_in.r2        = r2;
      s2_ent_in.room      = lim_ext - r2;
      s2_ent_in.reach_err = (r2 == '0) || (r2 > lim_ext);
   end

   // handshake between the two stages and the queue
   assign s2_free   = !s2_valid_ff || !q_full;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign q_push    = s2_valid_ff && !q_full;
   assign q_data    = s2_ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_x_ff   <= req_target_x;
         s1_y_ff   <= req_target_y;
         s1_xsq_ff <= s1_xsq_in;
         s1_ysq_ff <= s1_ysq_in;
         s1_lim_ff <= s1_lim_in;
      end
      if (s2_free) begin
         s2_ent_ff <= s2_ent_in;
      end
   end

endmodule

// ===== rtl/core/tlik_queue.sv =====
`timescale 1ns / 1ps
module tlik_queue import tlik_pkg::*; #(
   parameter int W     = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/tlik_isqrt.sv =====
`timescale 1ns / 1ps
module tlik_isqrt import tlik_pkg::*; #(
   parameter int IN_W   = SQ_IN_W,
   parameter int SIDE_W = COORD_W
) (
   input  logic                clock,
   input  logic                en,
   input  logic [IN_W-1:0]     in_val,
   input  logic [SIDE_W-1:0]   in_side,
   output logic [IN_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int NS = IN_W / 2;
   localparam int RW = IN_W + 1;

   logic [RW-1:0]     rem_ff [NS];
   logic [RW-1:0]     res_ff [NS];
   logic [SIDE_W-1:0] side_ff [NS];
   logic [RW-1:0]     rem_src [NS];
   logic [RW-1:0]     res_src [NS];
   logic [RW-1:0]     rem_in [NS];
   logic [RW-1:0]     res_in [NS];

   // one root bit per stage, restoring digit recurrence
   always_comb begin
      logic [RW-1:0] trial;
      logic [RW-1:0] bitv;
      rem_src[0] = RW'(in_val);
      res_src[0] = '0;
      for (int i = 1; i < NS; i++) begin
         rem_src[i] = rem_ff[i-1];
         res_src[i] = res_ff[i-1];
      end
      for (int i = 0; i < NS; i++) begin
         bitv  = RW'(1) << (2 * (NS - 1 - i));
         trial = res_src[i] + bitv;
         if (rem_src[i] >= trial) begin
            rem_in[i] = rem_src[i] - trial;
            res_in[i] = (res_src[i] >> 1) + bitv;
         end else begin
            rem_in[i] = rem_src[i];
            res_in[i] = res_src[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NS; i++) begin
            rem_ff[i] <= rem_in[i];
            res_ff[i] <= res_in[i];
         end
         side_ff[0] <= in_side;
         for (int i = 1; i < NS; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_root = res_ff[NS-1][NS-1:0];
   assign out_side = side_ff[NS-1];

endmodule

// ===== rtl/core/tlik_cordic.sv =====
`timescale 1ns / 1ps
module tlik_cordic import tlik_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF,
   parameter int FRAC   = ANGLE_FRAC_DEF,
   parameter int W      = CORDIC_W,
   parameter int AW     = ANGLE_FRAC_DEF + 12
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [W-1:0]  in_x,
   input  logic signed [W-1:0]  in_y,
   output logic signed [AW-1:0] out_z
);

   localparam logic signed [AW-1:0] D180 = AW'(longint'(180) << FRAC);

   logic signed [W-1:0]  x_ff [STAGES+1];
   logic signed [W-1:0]  y_ff [STAGES+1];
   logic signed [AW-1:0] z_ff [STAGES+1];
   logic signed [W-1:0]  x_in [STAGES+1];
   logic signed [W-1:0]  y_in [STAGES+1];
   logic signed [AW-1:0] z_in [STAGES+1];

   // left half plane is mirrored first, then one micro-rotation per stage
   always_comb begin
      logic signed [W-1:0]  dx;
      logic signed [W-1:0]  dy;
      logic signed [AW-1:0] ang;
      if (in_x < 0) begin
         x_in[0] = -in_x;
         y_in[0] = -in_y;
         z_in[0] = (in_y >= 0) ? D180 : -D180;
      end else begin
         x_in[0] = in_x;
         y_in[0] = in_y;
         z_in[0] = '0;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx  = y_ff[i] >>> i;
         dy  = x_ff[i] >>> i;
         ang = AW'(atan_angle(i, FRAC));
         if (y_ff[i] < 0) begin
            x_in[i+1] = x_ff[i] - dx;
            y_in[i+1] = y_ff[i] + dy;
            z_in[i+1] = z_ff[i] - ang;
         end else begin
            x_in[i+1] = x_ff[i] + dx;
            y_in[i+1] = y_ff[i] - dy;
            z_in[i+1] = z_ff[i] + ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= STAGES; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign out_z = z_ff[STAGES];

endmodule

// ===== rtl/core/tlik_div.sv =====
`timescale 1ns / 1ps
module tlik_div import tlik_pkg::*; #(
   parameter int W    = DIV_W,
   parameter int DV_W = SPAN_W
) (
   input  logic            clock,
   input  logic            en,
   input  logic [W-1:0]    in_mag,
   input  logic            in_neg,
   input  logic [DV_W-1:0] divisor,
   output logic [W-1:0]    out_quot,
   output logic            out_rem_nz,
   output logic            out_neg
);

   logic [W-1:0]    num_ff [W];
   logic [W-1:0]    quot_ff [W];
   logic [DV_W:0]   rem_ff [W];
   logic            neg_ff [W];
   logic [W-1:0]    num_src [W];
   logic [W-1:0]    quot_src [W];
   logic [DV_W:0]   rem_src [W];
   logic [W-1:0]    num_in [W];
   logic [W-1:0]    quot_in [W];
   logic [DV_W:0]   rem_in [W];

   // restoring division, one quotient bit per stage
   always_comb begin
      logic [DV_W:0] rem_sh;
      logic          qb;
      num_src[0]  = in_mag;
      quot_src[0] = '0;
      rem_src[0]  = '0;
      for (int i = 1; i < W; i++) begin
         num_src[i]  = num_ff[i-1];
         quot_src[i] = quot_ff[i-1];
         rem_src[i]  = rem_ff[i-1];
      end
      for (int i = 0; i < W; i++) begin
         rem_sh = {rem_src[i][DV_W-1:0], num_src[i][W-1]};
         qb     = (rem_sh >= {1'b0, divisor});
         rem_in[i]  = qb ? (rem_sh - {1'b0, divisor}) : rem_sh;
         quot_in[i] = {quot_src[i][W-2:0], qb};
         num_in[i]  = num_src[i] << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < W; i++) begin
            num_ff[i]  <= num_in[i];
            quot_ff[i] <= quot_in[i];
            rem_ff[i]  <= rem_in[i];
         end
         neg_ff[0] <= in_neg;
         for (int i = 1; i < W; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   assign out_quot   = quot_ff[W-1];
   assign out_rem_nz = (rem_ff[W-1] != '0);
   assign out_neg    = neg_ff[W-1];

endmodule

// ===== rtl/core/tlik_back.sv =====
`timescale 1ns / 1ps
module tlik_back import tlik_pkg::*; #(
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  qent_type            q_data,
   output logic                q_pop,
   input  cfg_type             cfg,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [SERVO_W-1:0]  rsp_hip_servo,
   output logic [SERVO_W-1:0]  rsp_knee_servo
);

   localparam int FRAC = ANGLE_FRAC_BITS;
   localparam int NS   = SQ_IN_W / 2;
   localparam int LINE = NS + CORDIC_STAGES + 1;
   localparam int AW   = FRAC + 12;
   localparam int NW   = AW + SERVO_W + 1;
   localparam int SW   = DIV_W + 2;

   localparam logic signed [AW-1:0] D90  = AW'(longint'(90) << FRAC);
   localparam logic signed [AW-1:0] D180 = AW'(longint'(180) << FRAC);
   localparam logic signed [AW-1:0] D360 = AW'(longint'(360) << FRAC);

   typedef struct packed {
      logic valid;
      logic reach_err;
   } ptag_type;

   typedef struct packed {
      logic       valid;
      status_type status;
   } stag_type;

   function automatic logic signed [AW-1:0] wrap180(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] r;
      r = v;
      if (r > D180) begin
         r = r - D360;
      end
      if (r < -D180) begin
         r = r + D360;
      end
      return r;
   endfunction

   function automatic logic signed [AW-1:0] wrap360(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] r;
      r = v;
      if (r >= D360) begin
         r = r - D360;
      end
      if (r < 0) begin
         r = r + D360;
      end
      return r;
   endfunction

   logic en;
   logic rsp_valid_ff;

   // whole back end advances when the output register can take a result
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = en && q_valid;
   assign rsp_valid = rsp_valid_ff;

   // square roots of r^2 and of 4L^2 - r^2, target rides along
   logic [NS-1:0]        c_root, s_root;
   logic [COORD_W-1:0]   x_side, y_side;
   logic signed [CORDIC_W-1:0] phi_x, phi_y, half_x, half_y;
   logic signed [AW-1:0] phi_z, half_z;

   tlik_isqrt #(.IN_W(SQ_IN_W), .SIDE_W(COORD_W)) u_sqrt_c (
      .clock    (clock),
      .en       (en),
      .in_val   (SQ_IN_W'(q_data.r2) << SQRT_SCALE),
      .in_side  (q_data.x),
      .out_root (c_root),
      .out_side (x_side)
   );

   tlik_isqrt #(.IN_W(SQ_IN_W), .SIDE_W(COORD_W)) u_sqrt_s (
      .clock    (clock),
      .en       (en),
      .in_val   (SQ_IN_W'(q_data.room) << SQRT_SCALE),
      .in_side  (q_data.y),
      .out_root (s_root),
      .out_side (y_side)
   );

   // bearing and half angle vectoring
   assign phi_x  = CORDIC_W'(signed'(x_side)) <<< PHI_SCALE;
   assign phi_y  = CORDIC_W'(signed'(y_side)) <<< PHI_SCALE;
   assign half_x = signed'(CORDIC_W'(c_root)) <<< HALF_SCALE;
   assign half_y = signed'(CORDIC_W'(s_root)) <<< HALF_SCALE;

   tlik_cordic #(.STAGES(CORDIC_STAGES), .FRAC(FRAC), .W(CORDIC_W), .AW(AW)) u_cordic_phi (
      .clock (clock),
      .en    (en),
      .in_x  (phi_x),
      .in_y  (phi_y),
      .out_z (phi_z)
   );

   tlik_cordic #(.STAGES(CORDIC_STAGES), .FRAC(FRAC), .W(CORDIC_W), .AW(AW)) u_cordic_half (
      .clock (clock),
      .en    (en),
      .in_x  (half_x),
      .in_y  (half_y),
      .out_z (half_z)
   );

   // tag line alongside the root and vectoring units
   ptag_type tag_ff [LINE];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE; i++) begin
            tag_ff[i] <= '0;
         end
      end else if (en) begin
         tag_ff[0] <= '{valid: q_valid, reach_err: q_data.reach_err};
         for (int i = 1; i < LINE; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   // post stages: clamp, candidate angles, knees, distances, select, scale, sign split
   ptag_type             t1_ff, t2_ff, t3_ff, t4_ff;
   stag_type             t5_ff, t6_ff, t7_ff;
   logic signed [AW-1:0] phi1_ff, half1_ff, half1_in;
   logic signed [AW-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [AW-1:0] a1_in, b1_in, a2_in, b2_in;
   logic signed [AW-1:0] a1_3ff, b1_3ff, a2_3ff, b2_3ff, k1_ff, k2_ff, k1_in, k2_in;
   logic                 v1_ff, v2_ff, v1_in, v2_in;
   logic signed [AW-1:0] a1_4ff, b1_4ff, a2_4ff, b2_4ff, d1_ff, d2_ff, d1_in, d2_in;
   logic                 v1_4ff, v2_4ff;
   logic signed [AW-1:0] a_ff, b_ff, a_in, b_in;
   status_type           st5_in;
   logic signed [NW-1:0] num_a_ff, num_b_ff, num_a_in, num_b_in;
   logic [DIV_W-1:0]     mag_a_ff, mag_b_ff, mag_a_in, mag_b_in;
   logic                 neg_a_ff, neg_b_ff, neg_a_in, neg_b_in;

   always_comb begin
      logic signed [AW-1:0] k1d;
      logic signed [AW-1:0] k2d;
      logic signed [NW-1:0] ta;
      logic signed [NW-1:0] tb;
      logic signed [NW-1:0] ma;
      logic signed [NW-1:0] mb;
      // half angle held to [0, 90]
      if (half_z < 0) begin
         half1_in = '0;
      end else if (half_z > D90) begin
         half1_in = D90;
      end else begin
         half1_in = half_z;
      end
      // two elbow solutions
      a1_in = wrap180(phi1_ff - half1_ff);
      b1_in = wrap180(phi1_ff - D180 + half1_ff);
      a2_in = wrap180(phi1_ff + half1_ff);
      b2_in = wrap180(phi1_ff + D180 - half1_ff);
      // knee angles and validity
      k1_in = wrap360(D360 + a1_ff - b1_ff);
      k2_in = wrap360(D360 + a2_ff - b2_ff);
      v1_in = (a1_ff >= -D180) && (a1_ff <= 0) && (b1_ff >= -D180) && (b1_ff <= D180)
              && (k1_in > 0);
      v2_in = (a2_ff >= -D180) && (a2_ff <= 0) && (b2_ff >= -D180) && (b2_ff <= D180)
              && (k2_in > 0);
      // distance of each knee from a right angle
      k1d   = k1_ff - D90;
      k2d   = k2_ff - D90;
      d1_in = (k1d < 0) ? -k1d : k1d;
      d2_in = (k2d < 0) ? -k2d : k2d;
      // choose a solution
      a_in   = a2_4ff;
      b_in   = b2_4ff;
      st5_in = ST_OK;
      if (v1_4ff && v2_4ff) begin
         if (d1_ff < d2_ff) begin
            a_in = a1_4ff;
            b_in = b1_4ff;
         end
      end else if (v1_4ff) begin
         a_in = a1_4ff;
         b_in = b1_4ff;
      end else if (!v2_4ff) begin
         st5_in = ST_NOSOL;
      end
      if (t4_ff.reach_err) begin
         st5_in = ST_REACH;
      end
      // angle times servo count span
      num_a_in = a_ff * signed'(NW'(cfg.count_span));
      num_b_in = b_ff * signed'(NW'(cfg.count_span));
      // drop the angle fraction with floor, split into sign and magnitude
      ta       = num_a_ff >>> FRAC;
      tb       = num_b_ff >>> FRAC;
      neg_a_in = (ta < 0);
      neg_b_in = (tb < 0);
      ma       = neg_a_in ? -ta : ta;
      mb       = neg_b_in ? -tb : tb;
      mag_a_in = ma[DIV_W-1:0];
      mag_b_in = mb[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
         t4_ff <= '0;
         t5_ff <= '0;
         t6_ff <= '0;
         t7_ff <= '0;
      end else if (en) begin
         t1_ff <= tag_ff[LINE-1];
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
         t5_ff <= '{valid: t4_ff.valid, status: st5_in};
         t6_ff <= t5_ff;
         t7_ff <= t6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phi1_ff  <= phi_z;
         half1_ff <= half1_in;
         a1_ff    <= a1_in;
         b1_ff    <= b1_in;
         a2_ff    <= a2_in;
         b2_ff    <= b2_in;
         a1_3ff   <= a1_ff;
         b1_3ff   <= b1_ff;
         a2_3ff   <= a2_ff;
         b2_3ff   <= b2_ff;
         k1_ff    <= k1_in;
         k2_ff    <= k2_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         a1_4ff   <= a1_3ff;
         b1_4ff   <= b1_3ff;
         a2_4ff   <= a2_3ff;
         b2_4ff   <= b2_3ff;
         v1_4ff   <= v1_ff;
         v2_4ff   <= v2_ff;
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         num_a_ff <= num_a_in;
         num_b_ff <= num_b_in;
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         neg_a_ff <= neg_a_in;
         neg_b_ff <= neg_b_in;
      end
   end

   // division by the angle span
   logic [DIV_W-1:0] quot_a, quot_b;
   logic             rnz_a, rnz_b, dneg_a, dneg_b;

   tlik_div #(.W(DIV_W), .DV_W(SPAN_W)) u_div_hip (
      .clock      (clock),
      .en         (en),
      .in_mag     (mag_a_ff),
      .in_neg     (neg_a_ff),
      .divisor    (cfg.angle_span),
      .out_quot   (quot_a),
      .out_rem_nz (rnz_a),
      .out_neg    (dneg_a)
   );

   tlik_div #(.W(DIV_W), .DV_W(SPAN_W)) u_div_knee (
      .clock      (clock),
      .en         (en),
      .in_mag     (mag_b_ff),
      .in_neg     (neg_b_ff),
      .divisor    (cfg.angle_span),
      .out_quot   (quot_b),
      .out_rem_nz (rnz_b),
      .out_neg    (dneg_b)
   );

   stag_type dtag_ff [DIV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_W; i++) begin
            dtag_ff[i] <= '0;
         end
      end else if (en) begin
         dtag_ff[0] <= t7_ff;
         for (int i = 1; i < DIV_W; i++) begin
            dtag_ff[i] <= dtag_ff[i-1];
         end
      end
   end

   // floor quotient, center offset and saturation
   logic [SERVO_W-1:0] hip_in, knee_in, hip_ff, knee_ff;
   status_type         status_ff;

   always_comb begin
      logic signed [SW-1:0] qa;
      logic signed [SW-1:0] qb;
      logic signed [SW-1:0] va;
      logic signed [SW-1:0] vb;
      qa = dneg_a ? -(SW'(quot_a) + SW'(rnz_a)) : SW'(quot_a);
      qb = dneg_b ? -(SW'(quot_b) + SW'(rnz_b)) : SW'(quot_b);
      va = SW'(cfg.zero_count) + qa;
      vb = SW'(cfg.zero_count) + qb;
      if (va < SW'(SERVO_MIN)) begin
         va = SW'(SERVO_MIN);
      end else if (va > SW'(SERVO_MAX)) begin
         va = SW'(SERVO_MAX);
      end
      if (vb < SW'(SERVO_MIN)) begin
         vb = SW'(SERVO_MIN);
      end else if (vb > SW'(SERVO_MAX)) begin
         vb = SW'(SERVO_MAX);
      end
      if (dtag_ff[DIV_W-1].status == ST_OK) begin
         hip_in  = va[SERVO_W-1:0];
         knee_in = vb[SERVO_W-1:0];
      end else begin
         hip_in  = '0;
         knee_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dtag_ff[DIV_W-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hip_ff    <= hip_in;
         knee_ff   <= knee_in;
         status_ff <= dtag_ff[DIV_W-1].status;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_hip_servo  = hip_ff;
   assign rsp_knee_servo = knee_ff;

endmodule

// ===== rtl/core/two_link_leg_inverse_kinematics.sv =====
`timescale 1ns / 1ps
// channel  | ports                                     | flow control
// req      | req_valid, req_target_x, req_target_y     | req_stall from block
// rsp      | rsp_valid, rsp_status, rsp_hip/knee_servo | rsp_stall from sink
// csr      | csr_valid, csr_index, csr_data            | csr_ready, always high
//
// one target per cycle sustained while rsp_stall is low; latency is set by the
// 26 square root stages, the vectoring stages and the 21 divider stages.
// reset is synchronous and clears the valid bits, the queue and the configuration registers.
// a stalled result freezes the back end; the two-entry queue then fills and
// req_stall rises once the front pipeline is also full.
`include "two_link_leg_inverse_kinematics_assert.svh"
module two_link_leg_inverse_kinematics import tlik_pkg::*; #(
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_target_x,
   input  logic signed [COORD_W-1:0] req_target_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [SERVO_W-1:0]        rsp_hip_servo,
   output logic [SERVO_W-1:0]        rsp_knee_servo,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   cfg_type  cfg_ff, cfg_in, cfg_eff;
   logic     q_push, q_full, q_pop, q_valid;
   qent_type q_wr_data, q_rd_data;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LINK:   cfg_in.link_length = csr_data[LINK_W-1:0];
            CSR_CENTER: cfg_in.zero_count  = csr_data[SERVO_W-1:0];
            CSR_RANGE:  cfg_in.count_span  = csr_data[SERVO_W-1:0];
            CSR_SPAN:   cfg_in.angle_span  = csr_data[SPAN_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{link_length: LINK_RST, zero_count: CENTER_RST,
                     count_span: RANGE_RST, angle_span: SPAN_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a zero span counts as one degree
   always_comb begin
      cfg_eff = cfg_ff;
      if (cfg_ff.angle_span == '0) begin
         cfg_eff.angle_span = SPAN_W'(1);
      end
   end

   tlik_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .link_length  (cfg_ff.link_length),
      .q_push       (q_push),
      .q_full       (q_full),
      .q_data       (q_wr_data)
   );

   tlik_queue #(.W($bits(qent_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .not_empty (q_valid)
   );

   tlik_back #(
      .CORDIC_STAGES   (CORDIC_STAGES),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (q_rd_data),
      .q_pop          (q_pop),
      .cfg            (cfg_eff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_hip_servo  (rsp_hip_servo),
      .rsp_knee_servo (rsp_knee_servo)
   );

   // result flags for the checks
   logic ok_rsp, err_rsp, counts_ok, counts_zero;

   assign ok_rsp      = rsp_valid && (rsp_status == ST_OK);
   assign err_rsp     = rsp_valid && (rsp_status != ST_OK);
   assign counts_ok   = (rsp_hip_servo >= SERVO_W'(SERVO_MIN))
                        && (rsp_hip_servo <= SERVO_W'(SERVO_MAX))
                        && (rsp_knee_servo >= SERVO_W'(SERVO_MIN))
                        && (rsp_knee_servo <= SERVO_W'(SERVO_MAX));
   assign counts_zero = (rsp_hip_servo == '0) && (rsp_knee_servo == '0);

   // result checks
   `TLIK_ASSERT(a_ok_in_range, clock, reset, ok_rsp |-> counts_ok, "count out of range")
   `TLIK_ASSERT(a_err_zero, clock, reset, err_rsp |-> counts_zero, "nonzero count on error")
   `TLIK_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "valid after reset")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import tlik_pkg::*;

   localparam int LATENCY    = CORDIC_STAGES_DEF + 58;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAB_SHIFT  = 24 - ANGLE_FRAC_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd9;
   localparam longint DEG180 = longint'(180) <<< ANGLE_FRAC_DEF;
   localparam longint DEG90  = longint'(90) <<< ANGLE_FRAC_DEF;
   localparam longint DEG360 = longint'(360) <<< ANGLE_FRAC_DEF;

   typedef struct {
      status_type         status;
      logic [SERVO_W-1:0] hip;
      logic [SERVO_W-1:0] knee;
   } joint_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_target_x;
   logic signed [COORD_W-1:0] req_target_y;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_status;
   logic [SERVO_W-1:0]        rsp_hip_servo;
   logic [SERVO_W-1:0]        rsp_knee_servo;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;

   // shadow copy of the block's registers
   longint link_len, center, range_cnt, span_deg;

   joint_result_type pending_joints[$];
   int            fail_count;
   int            quiet_cycles;
   bit            idle_on;
   bit            hold_req;

   two_link_leg_inverse_kinematics uut (.*);

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------- predictor ----------------
   function automatic longint vector_angle(longint vx, longint vy);
      longint z, dx, dy, t;
      z = 0;
      if (vx < 0) begin
         z  = (vy >= 0) ? DEG180 : -DEG180;
         vx = -vx;
         vy = -vy;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_LEN; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         t  = (ATAN_Q24[i] + (longint'(1) << (TAB_SHIFT - 1))) >>> TAB_SHIFT;
         if (vy < 0) begin
            vx = vx - dx;
            vy = vy + dy;
            z  = z - t;
         end else begin
            vx = vx + dx;
            vy = vy - dy;
            z  = z + t;
         end
      end
      return z;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint wrap_half_turn(longint v);
      if (v > DEG180) v = v - DEG360;
      if (v < -DEG180) v = v + DEG360;
      return v;
   endfunction

   function automatic longint wrap_full_turn(longint v);
      if (v >= DEG360) v = v - DEG360;
      if (v < 0) v = v + DEG360;
      return v;
   endfunction

   function automatic logic [SERVO_W-1:0] angle_to_count(longint a);
      longint den, num, q, v;
      den = ((span_deg == 0) ? longint'(1) : span_deg) <<< ANGLE_FRAC_DEF;
      num = a * range_cnt;
      q   = num / den;
      if (num < 0 && q * den != num) q = q - 1;
      v = center + q;
      if (v < SERVO_MIN) v = SERVO_MIN;
      if (v > SERVO_MAX) v = SERVO_MAX;
      return v[SERVO_W-1:0];
   endfunction

   function automatic joint_result_type solve_leg(logic signed [COORD_W-1:0] tx,
                                                  logic signed [COORD_W-1:0] ty);
      joint_result_type res;
      longint x, y, r2, lim, phi, half, a1, b1, a2, b2, k1, k2, d1, d2;
      longint unsigned s, c;
      bit v1, v2, pick1;
      x = tx;
      y = ty;
      res.status = ST_OK;
      res.hip    = '0;
      res.knee   = '0;
      r2  = x * x + y * y;
      lim = 4 * link_len * link_len;
      if (r2 == 0 || r2 > lim) begin
         res.status = ST_REACH;
         return res;
      end
      phi  = vector_angle(x * (longint'(1) << PHI_SCALE), y * (longint'(1) << PHI_SCALE));
      s    = int_sqrt(longint'(lim - r2) << SQRT_SCALE);
      c    = int_sqrt(longint'(r2) << SQRT_SCALE);
      half = vector_angle(longint'(c) * (longint'(1) << HALF_SCALE),
                          longint'(s) * (longint'(1) << HALF_SCALE));
      if (half < 0) half = 0;
      if (half > DEG90) half = DEG90;
      a1 = wrap_half_turn(phi - half);
      b1 = wrap_half_turn(phi - DEG180 + half);
      a2 = wrap_half_turn(phi + half);
      b2 = wrap_half_turn(phi + DEG180 - half);
      k1 = wrap_full_turn(DEG360 + a1 - b1);
      k2 = wrap_full_turn(DEG360 + a2 - b2);
      v1 = a1 >= -DEG180 && a1 <= 0 && b1 >= -DEG180 && b1 <= DEG180 && k1 > 0;
      v2 = a2 >= -DEG180 && a2 <= 0 && b2 >= -DEG180 && b2 <= DEG180 && k2 > 0;
      if (!v1 && !v2) begin
         res.status = ST_NOSOL;
         return res;
      end
      // prefer the knee nearer a right angle, ties go to solution two
      d1 = (k1 > DEG90) ? k1 - DEG90 : DEG90 - k1;
      d2 = (k2 > DEG90) ? k2 - DEG90 : DEG90 - k2;
      pick1 = v1 && (!v2 || d1 < d2);
      res.hip  = angle_to_count(pick1 ? a1 : a2);
      res.knee = angle_to_count(pick1 ? b1 : b2);
      return res;
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      joint_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_joints.size() == 0) begin
            $error("result transaction with nothing expected");
            fail_count++;
         end else begin
            exp_r = pending_joints.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp_status);
               fail_count++;
            end
            if (rsp_hip_servo !== exp_r.hip) begin
               $error("hip_servo expected %0d actual %0d", exp_r.hip, rsp_hip_servo);
               fail_count++;
            end
            if (rsp_knee_servo !== exp_r.knee) begin
               $error("knee_servo expected %0d actual %0d", exp_r.knee, rsp_knee_servo);
               fail_count++;
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------- receiver stall ----------------
   always begin
      int n;
      @(negedge clock);
      if (hold_req) begin
         // long hold so the pipeline backs up into the request side
         rsp_stall = 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_req  = 1'b0;
         rsp_stall = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 17);
         rsp_stall = 1'b1;
         repeat (n - 1) @(negedge clock);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // ---------------- shared tasks ----------------
   task automatic send_target(logic signed [COORD_W-1:0] tx,
                              logic signed [COORD_W-1:0] ty);
      int n;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 17);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid    = 1'b1;
      req_target_x = tx;
      req_target_y = ty;
      do @(posedge clock); while (req_stall);
      pending_joints.push_back(solve_leg(tx, ty));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_joints.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LINK:   link_len  = value & 14'h3fff;
         CSR_CENTER: center    = value & 12'hfff;
         CSR_RANGE:  range_cnt = value & 12'hfff;
         CSR_SPAN:   span_deg  = value & 9'h1ff;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(longint l, longint c, longint r, longint s);
      wait_drained();
      write_reg(CSR_LINK, l);
      write_reg(CSR_CENTER, c);
      write_reg(CSR_RANGE, r);
      write_reg(CSR_SPAN, s);
   endtask

   // target mostly reachable and below the hip, sometimes anywhere
   task automatic random_target(output logic signed [COORD_W-1:0] tx,
                                output logic signed [COORD_W-1:0] ty);
      int reach;
      reach = (2 * link_len + 2 > 32767) ? 32767 : int'(2 * link_len + 2);
      case ($urandom_range(0, 9))
         0: begin
            tx = COORD_W'($urandom);
            ty = COORD_W'($urandom);
         end
         1: begin
            tx = COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
            ty = COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
         end
         default: begin
            tx = COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
            ty = COORD_W'(-int'($urandom_range(0, reach)));
         end
      endcase
   endtask

   task automatic run_random(int count);
      logic signed [COORD_W-1:0] tx, ty;
      repeat (count) begin
         random_target(tx, ty);
         send_target(tx, ty);
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      // origin, corners, exact reach edge and just past it, each quadrant
      send_target(0, 0);
      send_target(16'sh7fff, 16'sh7fff);
      send_target(-16'sh8000, -16'sh8000);
      send_target(-16'sh8000, 0);
      send_target(0, -3200);
      send_target(0, -3201);
      send_target(3200, 0);
      send_target(-3200, 0);
      send_target(0, 3200);
      send_target(0, -1);
      send_target(1, -1);
      send_target(-1, -1);
      send_target(-1, 1);
      send_target(2000, -1500);
      send_target(-2000, -1500);
      send_target(1500, 1500);
      send_target(-1500, 1000);
      send_target(100, -2262);
      send_target(2262, -2262);
      send_target(-2263, -2263);
   endtask

   task automatic test_config_sweep();
      // largest links, top counts, narrowest span
      set_config(16383, 4095, 4095, 1);
      run_random(170);
      // smallest link and zero counts, a 360 degree span
      set_config(1, 0, 0, 360);
      run_random(100);
      // zero span behaves as one degree, zero link reaches nothing
      set_config(0, 1000, 3000, 0);
      send_target(0, -1);
      send_target(5, 5);
      set_config(1600, 2048, 2048, 0);
      run_random(100);
      // unused index leaves everything alone
      wait_drained();
      write_reg(CSR_UNUSED, 14'h3fff);
      run_random(50);
      set_config($urandom_range(1, 16383), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(1, 360));
      run_random(170);
   endtask

   task automatic test_backpressure();
      logic signed [COORD_W-1:0] tx, ty;
      wait_drained();
      hold_req = 1'b1;
      repeat (120) begin
         random_target(tx, ty);
         send_target(tx, ty);
      end
      // sender waits for everything to come back
      wait_drained();
   endtask

   task automatic test_random_default();
      set_config(1600, 2048, 2048, 180);
      run_random(250);
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      set_config(8000, 2048, 1024, 90);
      run_random(150);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_target_x = '0;
      req_target_y = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      fail_count   = 0;
      quiet_cycles = 0;
      idle_on      = 1'b1;
      hold_req     = 1'b0;
      link_len     = LINK_RST;
      center       = CENTER_RST;
      range_cnt    = RANGE_RST;
      span_deg     = SPAN_RST;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_default();
      test_backpressure();
      test_config_sweep();
      test_steady_stream();

      wait_drained();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
